/* hw/rtl/pcpa_pkg.sv */
// Shared constants, codes and types for the per-CPU page free-list allocator.
// Used by the channel interfaces, the link RAM user and the top level.
// No dependencies.
package pcpa_pkg;

	// Sizing of the allocator
	localparam int CPU_COUNT  = 8;
	localparam int MAX_PAGES  = 32768;
	localparam int PAGE_BYTES = 4096;

	// Derived widths
	localparam int ADDR_W = 32;
	localparam int PG_SH  = $clog2(PAGE_BYTES);
	localparam int AW     = $clog2(MAX_PAGES);   // link RAM address bits
	localparam int LW     = AW + 1;              // page index incl. empty marker
	localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

	localparam logic [LW-1:0] EMPTY_MARK = LW'(MAX_PAGES);

	// Register defaults
	localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] REGION_STOP_RST  = 32'h8800_0000;

	// Request kinds
	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OOM     = 2'd1,
		ST_BADFREE = 2'd2
	} status_t;

	// Configuration register indexes
	typedef enum logic {
		REG_REGION_START = 1'b0,
		REG_REGION_STOP  = 1'b1
	} reg_idx_t;

endpackage

/* hw/rtl/pcpa_if.sv */
// Valid/ready channel interfaces for the allocator: request, response and
// configuration write. Depends on pcpa_pkg.

interface pcpa_req_if;
	import pcpa_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [2:0]        cpu;
	logic [ADDR_W-1:0] page_address;

	modport source (output valid, kind, cpu, page_address, input ready);
	modport sink   (input valid, kind, cpu, page_address, output ready);
endinterface

interface pcpa_rsp_if;
	import pcpa_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] granted_address;
	logic [1:0]        status;
	logic              stolen;

	modport source (output valid, granted_address, status, stolen, input ready);
	modport sink   (input valid, granted_address, status, stolen, output ready);
endinterface

interface pcpa_cfg_if;
	import pcpa_pkg::*;
	logic              valid;
	logic              ready;
	logic              index;
	logic [ADDR_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/pcpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/per_cpu_page_free_list_allocator.sv */
// Per-CPU page free-list allocator with stealing; one shared 32-bit add/sub
// unit under a small sequencer. Uses pcpa_pkg, pcpa_if channels, pcpa_ram.
// Free: low range compare with alignment check, high range compare, index
//   subtract, then result; a misaligned or low address returns early.
// Allocate from own list: head read, link RAM read, then result.
//   A steal scans other CPUs' heads in turn; requests are taken only in idle.
// Reset: all list heads empty, registers at defaults; link RAM not cleared.
module per_cpu_page_free_list_allocator (
	input  logic           clk,
	input  logic           arst_n,
	pcpa_req_if.sink       req,
	pcpa_rsp_if.source     rsp,
	pcpa_cfg_if.sink       cfg
);
	import pcpa_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CHK_LO = 8'b0000_0010,
		S_CHK_HI = 8'b0000_0100,
		S_IDX    = 8'b0000_1000,
		S_POP    = 8'b0001_0000,
		S_SCAN   = 8'b0010_0000,
		S_LINK   = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] region_start_q;
	logic [ADDR_W-1:0] region_stop_q;
	logic [LW-1:0]     head_q [CPU_COUNT];
	logic [CPU_W-1:0]  hsel_q;
	logic [CPU_W-1:0]  cpu_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LW-1:0]     idx_q;
	logic [ADDR_W-1:0] res_addr_q;
	status_t           res_status_q;
	logic              res_stolen_q;
	logic              rsp_valid_q;
	logic [ADDR_W-1:0] rsp_addr_q;
	logic [1:0]        rsp_status_q;
	logic              rsp_stolen_q;

	logic [ADDR_W-1:0] op_a;
	logic [ADDR_W-1:0] op_b;
	logic              op_sub;
	logic [ADDR_W:0]   sum;
	logic [LW-1:0]     head_rd;
	logic              head_full;
	logic              req_fire;
	logic              cpu_ok;
	logic              idx_ok;
	logic              out_free;
	logic              ram_we;
	logic              ram_re;
	logic [LW-1:0]     ram_rdata;

	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cpu_ok    = (32'(req.cpu) < CPU_COUNT);
	assign head_rd   = head_q[hsel_q];
	assign head_full = (head_rd != EMPTY_MARK);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign idx_ok    = (sum[ADDR_W-1:0] < ADDR_W'(MAX_PAGES));

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= REGION_START_RST;
			region_stop_q  <= REGION_STOP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_REGION_START: region_start_q <= cfg.data;
				REG_REGION_STOP:  region_stop_q  <= cfg.data;
				default:          ;
			endcase
		end
	end

	// shared add/sub unit: operands picked by sequencer state
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			S_CHK_LO: begin
				op_a   = addr_q;
				op_b   = region_start_q;
				op_sub = 1'b1;
			end
			S_CHK_HI: begin
				op_a   = addr_q;
				op_b   = region_stop_q;
				op_sub = 1'b1;
			end
			S_IDX: begin
				op_a   = addr_q >> PG_SH;
				op_b   = region_start_q >> PG_SH;
				op_sub = 1'b1;
			end
			S_LINK: begin
				op_a   = region_start_q >> PG_SH;
				op_b   = ADDR_W'(idx_q);
			end
			default: ;
		endcase
	end

	// carry out of a subtract means op_a >= op_b
	assign sum = {1'b0, op_a} + {1'b0, op_b ^ {ADDR_W{op_sub}}} + (ADDR_W + 1)'(op_sub);

	// link RAM: write on push, read of the popped head
	assign ram_we = (state_q == S_IDX) && idx_ok;
	assign ram_re = ((state_q == S_POP) || (state_q == S_SCAN)) && head_full;

	pcpa_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_PAGES)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sum[AW-1:0]),
		.wdata (head_rd),
		.re    (ram_re),
		.raddr (head_rd[AW-1:0]),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hsel_q  <= '0;
			for (int i = 0; i < CPU_COUNT; i++) begin
				head_q[i] <= EMPTY_MARK;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						hsel_q <= CPU_W'(req.cpu);
						if (!cpu_ok) begin
							state_q <= S_OUT;
						end else if (req.kind == KIND_FREE) begin
							state_q <= S_CHK_LO;
						end else begin
							state_q <= S_POP;
						end
					end
				end
				S_CHK_LO: begin
					if (!sum[ADDR_W] || (addr_q[PG_SH-1:0] != '0)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_CHK_HI;
					end
				end
				S_CHK_HI: begin
					state_q <= sum[ADDR_W] ? S_OUT : S_IDX;
				end
				S_IDX: begin
					if (idx_ok) begin
						head_q[hsel_q] <= sum[LW-1:0];
					end
					state_q <= S_OUT;
				end
				S_POP: begin
					if (head_full) begin
						state_q <= S_LINK;
					end else begin
						hsel_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (head_full && (hsel_q != cpu_q)) begin
						state_q <= S_LINK;
					end else if (hsel_q == CPU_W'(CPU_COUNT - 1)) begin
						state_q <= S_OUT;
					end else begin
						hsel_q <= hsel_q + CPU_W'(1);
					end
				end
				S_LINK: begin
					head_q[hsel_q] <= ram_rdata;
					state_q        <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture and result assembly
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					cpu_q        <= CPU_W'(req.cpu);
					addr_q       <= req.page_address;
					res_addr_q   <= '0;
					res_stolen_q <= 1'b0;
					if (cpu_ok) begin
						res_status_q <= ST_OK;
					end else if (req.kind == KIND_FREE) begin
						res_status_q <= ST_BADFREE;
					end else begin
						res_status_q <= ST_OOM;
					end
				end
			end
			S_CHK_LO: begin
				if (!sum[ADDR_W] || (addr_q[PG_SH-1:0] != '0)) begin
					res_status_q <= ST_BADFREE;
				end
			end
			S_CHK_HI: begin
				if (sum[ADDR_W]) begin
					res_status_q <= ST_BADFREE;
				end
			end
			S_IDX: begin
				if (!idx_ok) begin
					res_status_q <= ST_BADFREE;
				end
			end
			S_POP: begin
				idx_q <= head_rd;
			end
			S_SCAN: begin
				if (head_full && (hsel_q != cpu_q)) begin
					idx_q        <= head_rd;
					res_stolen_q <= 1'b1;
				end else if (hsel_q == CPU_W'(CPU_COUNT - 1)) begin
					res_status_q <= ST_OOM;
				end
			end
			S_LINK: begin
				res_addr_q <= sum[ADDR_W-1:0] << PG_SH;
			end
			default: ;
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			rsp_addr_q   <= res_addr_q;
			rsp_status_q <= res_status_q;
			rsp_stolen_q <= res_stolen_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.granted_address = rsp_addr_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.stolen          = rsp_stolen_q;

endmodule
